>>> hdl/rvam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rvam_pkg;

    localparam int KIND_W    = 2;
    localparam int IDX_W     = 4;
    localparam int STATUS_W  = 4;
    localparam int VERDICT_W = 2;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    localparam logic [KIND_W-1:0] KIND_WR_TRANS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_NODE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EVENT    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_WRITTEN    = 4'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_MOVED      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_TERMINAL   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_NO_TRANS   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_ABORT      = 4'd5;
    localparam logic [STATUS_W-1:0] ST_FROM_TERM  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NODE_MISS  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_STARTED    = 4'd8;
    localparam logic [STATUS_W-1:0] ST_START_REJ  = 4'd9;

    localparam logic [VERDICT_W-1:0] VERD_NV  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERD_V   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERD_IV  = 2'd2;
    localparam logic [VERDICT_W-1:0] VERD_BAD = 2'd3;

    localparam logic [1:0] POL_STOP_V  = 2'd1;
    localparam logic [1:0] POL_STOP_IV = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ABORT_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_NODE   = 1'd1;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic                 term;
        logic                 def;
    } t_node_attr;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] target;
    } t_trans;

    function automatic logic f_policy_hit(input logic [1:0] policy,
                                          input logic [VERDICT_W-1:0] v);
        return ((policy == POL_STOP_V) && (v == VERD_V)) ||
               ((policy == POL_STOP_IV) && (v == VERD_IV));
    endfunction

endpackage

`default_nettype wire

>>> hdl/rvam_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rvam_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 4,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/runtime_verdict_automaton_monitor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                    | payload
// s (items) | in        | i_s_tvalid / o_s_tready      | tuser kind, tdata fields
// m (result)| out       | o_m_tvalid / i_m_tready      | tdata status..halted
// cfg       | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// one item at a time: writes, rejected starts and ignored events go from IDLE to FIN,
// starts and other events pass RD1 (node read, transition read) before FIN, and
// a move also RD2 (target node read); each read step uses the registered ram output
// after reset both rams are swept clear while o_s_tready is low
// a held result stalls only the final step; the next item waits for that slot

module runtime_verdict_automaton_monitor_core #(
    parameter int MAX_NODES  = 16,
    parameter int MAX_EVENTS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // node[3:0], event_req[7:4], target[11:8], present[12], verdict_in[14:13],
    // terminal_in[15]
    input  wire logic [rvam_pkg::IN_W-1:0]       i_s_tdata,
    // kind[1:0]
    input  wire logic [rvam_pkg::KIND_W-1:0]     i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // status[3:0], verdict[5:4], state_now[9:6], halted[10], zero[15:11]
    output logic      [rvam_pkg::OUT_W-1:0]      o_m_tdata,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rvam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rvam_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import rvam_pkg::*;

    localparam int TR_DEPTH = MAX_NODES * MAX_EVENTS;
    localparam int NA_W     = $clog2(MAX_NODES);
    localparam int TA_W     = $clog2(TR_DEPTH);
    localparam int NODE_AW  = $bits(t_node_attr);
    localparam int TR_W     = $bits(t_trans);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [IDX_W-1:0]     r_ev, n_ev;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [IDX_W-1:0]     r_cur, n_cur;
    logic [VERDICT_W-1:0] r_verdict, n_verdict;
    logic                 r_stop, n_stop;
    logic                 r_run, n_run;
    logic [1:0]           r_policy;
    logic [IDX_W-1:0]     r_start;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_W-1:0]     r_out_data, n_out_data;
    logic [TA_W-1:0]      r_clr_cnt;

    logic [IDX_W-1:0]     in_node, in_ev, in_tgt;
    logic                 in_pres, in_term;
    logic [VERDICT_W-1:0] in_verd;
    logic                 s_accept;

    logic                 node_we;
    logic [NA_W-1:0]      node_waddr, node_raddr;
    t_node_attr           node_wdata, node_rdata;
    logic                 tr_we;
    logic [TA_W-1:0]      tr_waddr, tr_raddr;
    t_trans               tr_wdata, tr_rdata;

    logic                 wr_node_ok, wr_ev_ok;

    assign in_node = i_s_tdata[3:0];
    assign in_ev   = i_s_tdata[7:4];
    assign in_tgt  = i_s_tdata[11:8];
    assign in_pres = i_s_tdata[12];
    assign in_verd = i_s_tdata[14:13];
    assign in_term = i_s_tdata[15];

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign wr_node_ok = (32'(in_node) < MAX_NODES);
    assign wr_ev_ok   = (32'(in_ev) < MAX_EVENTS);

    // ram ports
    always_comb begin
        node_we    = 1'b0;
        node_waddr = NA_W'(in_node);
        node_wdata = '0;
        tr_we      = 1'b0;
        tr_waddr   = TA_W'(32'(in_node) * MAX_EVENTS + 32'(in_ev));
        tr_wdata   = '0;
        if (r_state == S_CLR) begin
            node_waddr = NA_W'(r_clr_cnt);
            node_we    = (32'(r_clr_cnt) < MAX_NODES);
            tr_waddr   = r_clr_cnt;
            tr_we      = 1'b1;
        end else if (s_accept) begin
            if (i_s_tuser == KIND_WR_TRANS) begin
                tr_we           = wr_node_ok && wr_ev_ok;
                tr_wdata.valid  = in_pres;
                tr_wdata.target = in_pres ? in_tgt : '0;
            end else if (i_s_tuser == KIND_WR_NODE) begin
                node_we            = wr_node_ok;
                node_wdata.def     = in_pres;
                node_wdata.term    = in_term;
                node_wdata.verdict = (in_verd == VERD_BAD) ? VERD_NV : in_verd;
            end
        end
    end

    always_comb begin
        tr_raddr = TA_W'(32'(r_cur) * MAX_EVENTS + 32'(in_ev));
        if (r_state == S_RD1) begin
            node_raddr = NA_W'(tr_rdata.target);
        end else if (i_s_tuser == KIND_START) begin
            node_raddr = NA_W'(r_start);
        end else begin
            node_raddr = NA_W'(r_cur);
        end
    end

    rvam_mem #(
        .DEPTH (MAX_NODES),
        .WIDTH (NODE_AW)
    ) u_node_mem (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    rvam_mem #(
        .DEPTH (TR_DEPTH),
        .WIDTH (TR_W)
    ) u_trans_mem (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (tr_waddr),
        .i_wdata (tr_wdata),
        .i_raddr (tr_raddr),
        .o_rdata (tr_rdata)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_ev        = r_ev;
        n_status    = r_status;
        n_cur       = r_cur;
        n_verdict   = r_verdict;
        n_stop      = r_stop;
        n_run       = r_run;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        case (r_state)
            S_CLR: begin
                if (32'(r_clr_cnt) == TR_DEPTH - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_kind = i_s_tuser;
                    n_ev   = in_ev;
                    n_state = S_FIN;
                    case (i_s_tuser)
                        KIND_WR_TRANS: begin
                            n_status = (wr_node_ok && wr_ev_ok) ? ST_WRITTEN : ST_IGNORED;
                        end
                        KIND_WR_NODE: begin
                            n_status = wr_node_ok ? ST_WRITTEN : ST_IGNORED;
                        end
                        KIND_START: begin
                            if (r_run) begin
                                n_stop   = 1'b1;
                                n_status = ST_START_REJ;
                            end else begin
                                n_state = S_RD1;
                            end
                        end
                        default: begin
                            if (r_stop || !r_run) begin
                                n_status = ST_IGNORED;
                            end else begin
                                n_state = S_RD1;
                            end
                        end
                    endcase
                end
            end
            S_RD1: begin
                n_state = S_FIN;
                if (r_kind == KIND_START) begin
                    n_verdict = VERD_NV;
                    n_stop    = 1'b0;
                    n_run     = 1'b1;
                    n_cur     = r_start;
                    n_status  = ST_STARTED;
                    if ((32'(r_start) < MAX_NODES) && node_rdata.def && node_rdata.term) begin
                        n_verdict = node_rdata.verdict;
                        n_stop    = 1'b1;
                        n_run     = 1'b0;
                        n_status  = f_policy_hit(r_policy, node_rdata.verdict) ?
                                    ST_ABORT : ST_TERMINAL;
                    end
                end else if (!(32'(r_cur) < MAX_NODES) || !node_rdata.def) begin
                    n_status = ST_NODE_MISS;
                end else if (node_rdata.term) begin
                    n_status = ST_FROM_TERM;
                end else if ((32'(r_ev) < MAX_EVENTS) && tr_rdata.valid) begin
                    n_cur   = tr_rdata.target;
                    n_state = S_RD2;
                end else begin
                    n_stop   = 1'b1;
                    n_status = ST_NO_TRANS;
                end
            end
            S_RD2: begin
                n_state  = S_FIN;
                n_status = ST_MOVED;
                if ((32'(r_cur) < MAX_NODES) && node_rdata.def) begin
                    n_verdict = node_rdata.verdict;
                    if (f_policy_hit(r_policy, node_rdata.verdict)) begin
                        n_stop   = 1'b1;
                        n_run    = 1'b0;
                        n_status = ST_ABORT;
                    end else if (node_rdata.term) begin
                        n_stop   = 1'b1;
                        n_run    = 1'b0;
                        n_status = ST_TERMINAL;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {5'b0, r_stop, r_cur, r_verdict, r_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cur       <= '0;
            r_verdict   <= VERD_NV;
            r_stop      <= 1'b0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_verdict   <= n_verdict;
            r_stop      <= n_stop;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
            if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= '0;
            r_start  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_ABORT_POLICY) begin
                r_policy <= i_cfg_data[1:0];
            end else if (i_cfg_index == CFG_START_NODE) begin
                r_start <= i_cfg_data[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_ev       <= n_ev;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("item accepted while another is in flight");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_verdict != VERD_BAD)
        else $error("verdict register holds an unused code");

    a_rd2_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD2) |-> (r_kind == KIND_EVENT) && ($past(r_state) == S_RD1))
        else $error("target read outside an event move");

    a_no_result_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_m_tvalid && !o_s_tready)
        else $error("activity during table sweep");

endmodule

`default_nettype wire

>>> tb/runtime_verdict_automaton_monitor_core_tb.sv
`timescale 1ns / 1ps

module runtime_verdict_automaton_monitor_core_tb;

    import rvam_pkg::*;

    // node[3:0], event_req[7:4], target[11:8], present[12], verdict_in[14:13],
    // terminal_in[15]
    typedef struct packed {
        logic                 term;
        logic [VERDICT_W-1:0] vin;
        logic                 pres;
        logic [IDX_W-1:0]     tgt;
        logic [IDX_W-1:0]     ev;
        logic [IDX_W-1:0]     node;
    } mon_item_t;

    // status[3:0], verdict[5:4], state_now[9:6], halted[10], pad[15:11]
    typedef struct packed {
        logic [4:0]           pad;
        logic                 halted;
        logic [IDX_W-1:0]     state_now;
        logic [VERDICT_W-1:0] verdict;
        logic [STATUS_W-1:0]  status;
    } mon_report_t;

    class verdict_tracker;
        t_node_attr           node_mem [16];
        t_trans               trans_mem [256];
        logic [IDX_W-1:0]     cur_node;
        logic [VERDICT_W-1:0] verdict_now;
        bit                   stop_q;
        bit                   run_q;
        logic [1:0]           policy;
        logic [IDX_W-1:0]     start_idx;
        mon_report_t          due_reports [$];
        int                   mismatches;

        function new();
            foreach (node_mem[i]) node_mem[i] = '0;
            foreach (trans_mem[i]) trans_mem[i] = '0;
            cur_node    = '0;
            verdict_now = VERD_NV;
            stop_q      = 1'b0;
            run_q       = 1'b0;
            policy      = '0;
            start_idx   = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == CFG_ABORT_POLICY) begin
                policy = data[1:0];
            end else begin
                start_idx = data[IDX_W-1:0];
            end
        endfunction

        function bit abort_hit(logic [VERDICT_W-1:0] v);
            return (policy == POL_STOP_V && v == VERD_V) ||
                   (policy == POL_STOP_IV && v == VERD_IV);
        endfunction

        // adopt the verdict of a defined node, then abort or terminal check
        function logic [STATUS_W-1:0] enter_node(logic [IDX_W-1:0] n,
                                                 logic [STATUS_W-1:0] quiet);
            if (!node_mem[n].def) return quiet;
            verdict_now = node_mem[n].verdict;
            if (abort_hit(verdict_now)) begin
                stop_q = 1'b1;
                run_q  = 1'b0;
                return ST_ABORT;
            end
            if (node_mem[n].term) begin
                stop_q = 1'b1;
                run_q  = 1'b0;
                return ST_TERMINAL;
            end
            return quiet;
        endfunction

        function void accept_item(logic [KIND_W-1:0] kind, mon_item_t it);
            logic [STATUS_W-1:0] st;
            mon_report_t         rep;
            t_trans              hop;
            st = ST_IGNORED;
            case (kind)
                KIND_WR_TRANS: begin
                    trans_mem[{it.node, it.ev}].valid  = it.pres;
                    trans_mem[{it.node, it.ev}].target = it.pres ? it.tgt : '0;
                    st = ST_WRITTEN;
                end
                KIND_WR_NODE: begin
                    node_mem[it.node].def     = it.pres;
                    node_mem[it.node].term    = it.term;
                    node_mem[it.node].verdict = (it.vin == VERD_BAD) ? VERD_NV : it.vin;
                    st = ST_WRITTEN;
                end
                KIND_START: begin
                    if (run_q) begin
                        stop_q = 1'b1;
                        st = ST_START_REJ;
                    end else begin
                        verdict_now = VERD_NV;
                        stop_q      = 1'b0;
                        run_q       = 1'b1;
                        cur_node    = start_idx;
                        st = ST_STARTED;
                        if (node_mem[cur_node].def && node_mem[cur_node].term)
                            st = enter_node(cur_node, ST_STARTED);
                    end
                end
                default: begin
                    if (stop_q || !run_q) begin
                        st = ST_IGNORED;
                    end else if (!node_mem[cur_node].def) begin
                        st = ST_NODE_MISS;
                    end else if (node_mem[cur_node].term) begin
                        st = ST_FROM_TERM;
                    end else begin
                        hop = trans_mem[{cur_node, it.ev}];
                        if (hop.valid) begin
                            cur_node = hop.target;
                            st = enter_node(cur_node, ST_MOVED);
                        end else begin
                            stop_q = 1'b1;
                            st = ST_NO_TRANS;
                        end
                    end
                end
            endcase
            rep           = '0;
            rep.status    = st;
            rep.verdict   = verdict_now;
            rep.state_now = cur_node;
            rep.halted    = stop_q;
            due_reports.push_back(rep);
        endfunction

        function void check_report(mon_report_t got);
            mon_report_t exp_rep;
            if (due_reports.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                mismatches++;
                return;
            end
            exp_rep = due_reports.pop_front();
            if (got.status !== exp_rep.status) begin
                $error("status mismatch: expected %0d, actual %0d", exp_rep.status, got.status);
                mismatches++;
            end
            if (got.verdict !== exp_rep.verdict) begin
                $error("verdict mismatch: expected %0d, actual %0d",
                       exp_rep.verdict, got.verdict);
                mismatches++;
            end
            if (got.state_now !== exp_rep.state_now) begin
                $error("state_now mismatch: expected %0d, actual %0d",
                       exp_rep.state_now, got.state_now);
                mismatches++;
            end
            if (got.halted !== exp_rep.halted) begin
                $error("halted mismatch: expected %0d, actual %0d", exp_rep.halted, got.halted);
                mismatches++;
            end
            if (got.pad !== exp_rep.pad) begin
                $error("pad mismatch: expected %0d, actual %0d", exp_rep.pad, got.pad);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_W-1:0]        i_s_tdata;
    logic [KIND_W-1:0]      i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_W-1:0]       o_m_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DAT_W-1:0]   i_cfg_data;

    verdict_tracker sb;
    int sent_cnt  = 0;
    int res_cnt   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    runtime_verdict_automaton_monitor_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result side: random stalls, one long hold-off, one stretch always ready
    always @(negedge i_clk) begin
        if (res_cnt == 150 && !hold_done) begin
            hold_left = 300;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            i_m_tready = 1'b0;
            hold_left--;
        end else if (res_cnt >= 500 && res_cnt < 620) begin
            i_m_tready = 1'b1;
        end else begin
            i_m_tready = ($urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_report(mon_report_t'(o_m_tdata));
            res_cnt++;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input mon_item_t it);
        while (!(sent_cnt >= 300 && sent_cnt < 420) && $urandom_range(0, 99) < 32) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = kind;
        i_s_tdata  = it;
        do @(posedge i_clk); while (!o_s_tready);
        sb.accept_item(kind, it);
        sent_cnt++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        while (sb.due_reports.size() != 0) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_phase(input logic [1:0] pol, input logic [IDX_W-1:0] start);
        write_reg(CFG_ABORT_POLICY, {2'($urandom), pol});
        write_reg(CFG_START_NODE, start);
    endtask

    task automatic wr_node(input logic [IDX_W-1:0] n, input logic pres, input logic term,
                           input logic [VERDICT_W-1:0] vin);
        mon_item_t it;
        it      = mon_item_t'(16'($urandom));
        it.node = n;
        it.pres = pres;
        it.term = term;
        it.vin  = vin;
        send_item(KIND_WR_NODE, it);
    endtask

    task automatic wr_trans(input logic [IDX_W-1:0] n, input logic [IDX_W-1:0] ev,
                            input logic [IDX_W-1:0] tgt, input logic pres);
        mon_item_t it;
        it      = mon_item_t'(16'($urandom));
        it.node = n;
        it.ev   = ev;
        it.tgt  = tgt;
        it.pres = pres;
        send_item(KIND_WR_TRANS, it);
    endtask

    task automatic start_run();
        send_item(KIND_START, mon_item_t'(16'($urandom)));
    endtask

    task automatic fire(input logic [IDX_W-1:0] ev);
        mon_item_t it;
        it    = mon_item_t'(16'($urandom));
        it.ev = ev;
        send_item(KIND_EVENT, it);
    endtask

    task automatic rand_node_write();
        wr_node(4'($urandom), $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0,
                2'($urandom));
    endtask

    task automatic rand_trans_write();
        wr_trans(4'($urandom), 4'($urandom), 4'($urandom), $urandom_range(0, 7) != 0);
    endtask

    // steers a run: starts only while no run is active or it is halted, events in a live
    // run mostly follow a valid transition, undefined or terminal nodes often repaired
    task automatic step_wellformed();
        t_node_attr       at;
        int               r;
        int               off;
        bit               found;
        logic [IDX_W-1:0] pick;
        r     = $urandom_range(0, 99);
        found = 1'b0;
        pick  = '0;
        if (sb.run_q && !sb.stop_q) begin
            at = sb.node_mem[sb.cur_node];
            if (r < 60) begin
                if (!at.def || at.term) begin
                    if ($urandom_range(0, 1)) fire(4'($urandom));
                    else wr_node(sb.cur_node, 1'b1, 1'b0, 2'($urandom));
                end else begin
                    off = $urandom_range(0, 15);
                    for (int k = 0; k < 16; k++) begin
                        if (!found && sb.trans_mem[{sb.cur_node, 4'(off + k)}].valid) begin
                            found = 1'b1;
                            pick  = 4'(off + k);
                        end
                    end
                    if (found) fire(pick);
                    else wr_trans(sb.cur_node, 4'($urandom), 4'($urandom), 1'b1);
                end
            end else if (r < 85) begin
                rand_node_write();
            end else begin
                rand_trans_write();
            end
        end else begin
            if (r < 35) start_run();
            else if (r < 50) fire(4'($urandom));
            else if (r < 80) rand_node_write();
            else rand_trans_write();
        end
    endtask

    initial begin
        logic [IDX_W-1:0] t;
        sb = new();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        set_phase(2'd0, 4'd0);
        fire(4'd0);
        start_run();
        fire(4'd15);
        wr_node(4'd0, 1'b1, 1'b0, VERD_BAD);
        wr_trans(4'd0, 4'd15, 4'd15, 1'b1);
        wr_trans(4'd0, 4'd0, 4'd5, 1'b1);
        wr_trans(4'd0, 4'd0, 4'd5, 1'b0);
        fire(4'd15);
        wr_node(4'd15, 1'b1, 1'b1, VERD_IV);
        fire(4'd3);
        wr_node(4'd15, 1'b1, 1'b0, VERD_V);
        wr_trans(4'd15, 4'd3, 4'd7, 1'b1);
        wr_node(4'd7, 1'b1, 1'b1, VERD_IV);
        fire(4'd3);
        fire(4'd3);
        set_phase(POL_STOP_V, 4'd15);
        start_run();
        wr_trans(4'd15, 4'd8, 4'd15, 1'b1);
        fire(4'd8);
        set_phase(POL_STOP_IV, 4'd7);
        start_run();
        set_phase(2'd0, 4'd7);
        start_run();
        set_phase(2'd3, 4'd0);
        start_run();

        for (int p = 0; p < 7; p++) begin
            set_phase(2'(p), (p == 0) ? 4'd0 : (p == 1) ? 4'd15 : 4'($urandom));
            repeat (115) step_wellformed();
        end

        // close the run cleanly, then a missing transition and a start
        // while active, then noise
        set_phase(2'd0, 4'd0);
        if (sb.run_q) begin
            t = sb.cur_node ^ 4'd1;
            wr_node(t, 1'b1, 1'b1, VERD_NV);
            wr_node(sb.cur_node, 1'b1, 1'b0, VERD_NV);
            wr_trans(sb.cur_node, 4'd0, t, 1'b1);
            fire(4'd0);
        end
        wr_node(4'd0, 1'b1, 1'b0, VERD_NV);
        wr_trans(4'd0, 4'd9, 4'd9, 1'b0);
        start_run();
        fire(4'd9);
        start_run();
        repeat (80) send_item(2'($urandom), mon_item_t'(16'($urandom)));

        while (sb.due_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/rvam_pkg.sv
hdl/rvam_mem.sv
hdl/runtime_verdict_automaton_monitor_core.sv
tb/runtime_verdict_automaton_monitor_core_tb.sv
